### rtl/bfdp_pkg.sv
package bfdp_pkg;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned SLOTS          = DEPTH + 1;
  localparam int unsigned IDX_W          = $clog2(SLOTS);
  localparam int unsigned CNT_W          = $clog2(DEPTH + 1);
  localparam int unsigned MAX_ITEM_BYTES = 8;
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned NB_W           = 4;
  localparam int unsigned CAP_W          = 5;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 5;
  localparam int unsigned IN_W           = 72;
  localparam int unsigned OUT_W          = 80;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY    = 2'd0,
    REG_ITEM_SIZE   = 2'd1,
    REG_DROP_OLDEST = 2'd2,
    REG_NOTIFY_EN   = 2'd3
  } reg_idx_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic [NB_W-1:0]  item_size;
    logic             drop_oldest;
    logic             notify_enable;
  } cfg_t;

  typedef struct packed {
    logic [NB_W-1:0]   item_bytes;
    logic [DATA_W-1:0] item_data;
    logic [1:0]        operation;
  } in_item_t;

  typedef struct packed {
    logic              dropped;
    logic              full_notify;
    logic [CNT_W-1:0]  occupancy;
    logic [NB_W-1:0]   out_bytes;
    logic [DATA_W-1:0] out_data;
    logic [1:0]        status;
  } res_t;

  typedef struct packed {
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

  function automatic logic [DATA_W-1:0] byte_mask(logic [NB_W-1:0] nbytes);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      if (NB_W'(i) < nbytes) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

### rtl/bfdp_ram.sv
module bfdp_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 17
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bfdp_core.sv
module bfdp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bfdp_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bfdp_pkg::in_item_t  in_item_i,
  input  logic                out_stall_i,
  output logic                res_load_o,
  output bfdp_pkg::res_t      res_o,
  output bfdp_pkg::ram_req_t  ram_o,
  input  logic [bfdp_pkg::DATA_W-1:0] ram_rdata_i
);

  bfdp_pkg::state_e state_q, state_d;

  logic [bfdp_pkg::IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [bfdp_pkg::IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [bfdp_pkg::CNT_W-1:0] count_q, count_d;
  logic [bfdp_pkg::SLOTS-1:0] valid_q, valid_d;

  bfdp_pkg::op_e                op_q;
  logic [bfdp_pkg::DATA_W-1:0]  data_q;
  logic [bfdp_pkg::NB_W-1:0]    nb_q;

  logic accept, commit;
  logic [bfdp_pkg::CAP_W-1:0]  ucap;
  logic [bfdp_pkg::NB_W-1:0]   isz;
  logic [bfdp_pkg::NB_W-1:0]   wbytes;
  logic [bfdp_pkg::DATA_W-1:0] old_data;
  logic [bfdp_pkg::DATA_W-1:0] wmask;
  logic [bfdp_pkg::IDX_W-1:0]  wr_adv, rd_adv;
  logic                        full;
  logic                        slot_valid;
  logic [bfdp_pkg::IDX_W-1:0]  slot_idx;

  function automatic logic [bfdp_pkg::IDX_W-1:0] advance(
    logic [bfdp_pkg::IDX_W-1:0] idx,
    logic [bfdp_pkg::CAP_W-1:0] cap
  );
    logic [bfdp_pkg::IDX_W:0] n;
    logic [bfdp_pkg::IDX_W:0] ring;
    n    = {1'b0, idx} + 1'b1;
    ring = (bfdp_pkg::IDX_W + 1)'(cap) + 1'b1;
    return (n >= ring) ? '0 : n[bfdp_pkg::IDX_W-1:0];
  endfunction

  // clamp registers to legal ranges
  always_comb begin
    ucap = cfg_i.capacity;
    if (ucap == '0) begin
      ucap = bfdp_pkg::CAP_W'(1);
    end else if (ucap > bfdp_pkg::CAP_W'(bfdp_pkg::DEPTH)) begin
      ucap = bfdp_pkg::CAP_W'(bfdp_pkg::DEPTH);
    end
    isz = cfg_i.item_size;
    if (isz == '0) begin
      isz = bfdp_pkg::NB_W'(1);
    end else if (isz > bfdp_pkg::NB_W'(bfdp_pkg::MAX_ITEM_BYTES)) begin
      isz = bfdp_pkg::NB_W'(bfdp_pkg::MAX_ITEM_BYTES);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bfdp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = bfdp_pkg::S_EXEC;
        end
      end
      bfdp_pkg::S_EXEC: begin
        if (!out_stall_i) begin
          state_d = bfdp_pkg::S_IDLE;
        end
      end
      default: state_d = bfdp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      bfdp_pkg::S_IDLE: in_ready_o = 1'b1;
      bfdp_pkg::S_EXEC: commit     = !out_stall_i;
      default: begin
        in_ready_o = 1'b0;
        commit     = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // slot under access: head for enqueue, tail otherwise
  assign slot_idx   = (op_q == bfdp_pkg::OP_ENQ) ? wr_idx_q : rd_idx_q;
  assign slot_valid = valid_q[slot_idx];
  assign old_data   = slot_valid ? ram_rdata_i : '0;
  assign full       = count_q >= bfdp_pkg::CNT_W'(ucap);
  assign wbytes     = (nb_q < isz) ? nb_q : isz;
  assign wmask      = bfdp_pkg::byte_mask(wbytes);
  assign wr_adv     = advance(wr_idx_q, ucap);
  assign rd_adv     = advance(rd_idx_q, ucap);

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    count_d  = count_q;
    valid_d  = valid_q;
    res_o    = '0;
    ram_o.re    = accept;
    ram_o.raddr = (bfdp_pkg::op_e'(in_item_i.operation) == bfdp_pkg::OP_ENQ) ?
                  wr_idx_q : rd_idx_q;
    ram_o.we    = 1'b0;
    ram_o.waddr = wr_idx_q;
    ram_o.wdata = (old_data & ~wmask) | (data_q & wmask);
    case (op_q)
      bfdp_pkg::OP_ENQ: begin
        res_o.full_notify = full && cfg_i.notify_enable;
        if (full && !cfg_i.drop_oldest) begin
          res_o.status = bfdp_pkg::STAT_FULL;
        end else begin
          ram_o.we = commit;
          valid_d[wr_idx_q] = 1'b1;
          wr_idx_d = wr_adv;
          if (full) begin
            res_o.dropped = 1'b1;
            rd_idx_d = rd_adv;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      bfdp_pkg::OP_DEQ: begin
        if (count_q == '0) begin
          res_o.status = bfdp_pkg::STAT_EMPTY;
        end else begin
          res_o.out_data  = old_data & bfdp_pkg::byte_mask(isz);
          res_o.out_bytes = isz;
          rd_idx_d = rd_adv;
          count_d  = count_q - 1'b1;
        end
      end
      default: ;
    endcase
    res_o.occupancy = count_d;
  end

  assign res_load_o = commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bfdp_pkg::S_IDLE;
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      count_q  <= '0;
      valid_q  <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        wr_idx_q <= wr_idx_d;
        rd_idx_q <= rd_idx_d;
        count_q  <= count_d;
        valid_q  <= valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= bfdp_pkg::op_e'(in_item_i.operation);
      data_q <= in_item_i.item_data;
      nb_q   <= in_item_i.item_bytes;
    end
  end

endmodule

### rtl/bounded_fifo_drop_policy.sv
// Bounded FIFO of 64-bit items with a drop-oldest or reject policy when full.
// Input stream s_axis: one item per command (enqueue, dequeue, occupancy query).
// Output stream m_axis: exactly one result item per command, in order.
// Config channel cfg_*: index 0 capacity, 1 item size, 2 drop oldest,
// 3 notify enable; always ready, write only while no command is in flight.
// Result: the command and its slot read are registered; the result register
// loads when not stalled, and only then is a new command taken. The slot RAM
// is read on accept; a stored enqueue writes back its partial byte merge at commit.
// Reset: queue empty, indexes zero, config at defaults; per-slot valid bits
// clear at once so every slot reads as zero until written, no clearing pass.
// Receiver stall: the result register holds; one more command may be taken
// and its slot read, then it waits until the result register drains.
module bounded_fifo_drop_policy (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] operation, [65:2] item_data, [69:66] item_bytes, [71:70] zero
  input  logic [bfdp_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] status, [65:2] out_data, [69:66] out_bytes, [74:70] occupancy,
  // [75] full_notify, [76] dropped, [79:77] zero
  output logic [bfdp_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bfdp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfdp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  bfdp_pkg::cfg_t     cfg_q;
  bfdp_pkg::in_item_t in_item;
  bfdp_pkg::res_t     res, res_q;
  bfdp_pkg::ram_req_t ram_req;
  logic [bfdp_pkg::DATA_W-1:0] ram_rdata;
  logic res_load;
  logic out_valid_q;
  logic out_stall;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity      <= bfdp_pkg::CAP_W'(bfdp_pkg::DEPTH);
      cfg_q.item_size     <= bfdp_pkg::NB_W'(bfdp_pkg::MAX_ITEM_BYTES);
      cfg_q.drop_oldest   <= 1'b0;
      cfg_q.notify_enable <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bfdp_pkg::reg_idx_e'(cfg_index_i))
        bfdp_pkg::REG_CAPACITY:    cfg_q.capacity      <= cfg_data_i;
        bfdp_pkg::REG_ITEM_SIZE:   cfg_q.item_size     <= cfg_data_i[bfdp_pkg::NB_W-1:0];
        bfdp_pkg::REG_DROP_OLDEST: cfg_q.drop_oldest   <= cfg_data_i[0];
        bfdp_pkg::REG_NOTIFY_EN:   cfg_q.notify_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_item = bfdp_pkg::in_item_t'(s_axis_tdata[$bits(bfdp_pkg::in_item_t)-1:0]);
  assign out_stall = out_valid_q && !m_axis_tready;

  bfdp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_stall_i (out_stall),
    .res_load_o  (res_load),
    .res_o       (res),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  bfdp_ram #(
    .Width (bfdp_pkg::DATA_W),
    .Depth (bfdp_pkg::SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = bfdp_pkg::OUT_W'(res_q);

endmodule
